/* src/sst_pkg.sv */
// Shared types and codes for the sorted set table.
`timescale 1ns / 1ps

package sst_pkg;

    // Fixed field widths of the request and result words
    localparam int IN_VALUE_W = 32;
    localparam int POS_W      = 4;
    localparam int CNT_W      = 5;

    typedef logic [1:0] t_mode;
    typedef logic [1:0] t_status;
    typedef logic [2:0] t_cmd;

    // Request modes
    localparam t_mode MODE_INSERT = 2'd0;
    localparam t_mode MODE_FIND   = 2'd1;
    localparam t_mode MODE_ERASE  = 2'd2;
    localparam t_mode MODE_CLEAR  = 2'd3;

    // Result status codes
    localparam t_status STAT_OK   = 2'd0;
    localparam t_status STAT_MISS = 2'd1;  // duplicate on insert, absent otherwise
    localparam t_status STAT_FULL = 2'd2;

    // Datapath commands
    localparam t_cmd CMD_NONE = 3'd0;
    localparam t_cmd CMD_LOAD = 3'd1;
    localparam t_cmd CMD_SCAN = 3'd2;
    localparam t_cmd CMD_UP   = 3'd3;
    localparam t_cmd CMD_DOWN = 3'd4;
    localparam t_cmd CMD_OUT  = 3'd5;

    // Datapath status back to the controller
    typedef struct packed {
        logic  scan_done;
        logic  found;
        logic  full;
        logic  shift_done;
        t_mode mode;
    } t_stat;

endpackage

/* src/sorted_set_table_unit.sv */
// Sorted set table: a controller and a datapath holding distinct values in ascending order.
// The scan and the shift each visit one entry per cycle through the single read port of the
//   entry memory. Words are taken one at a time, the next in the cycle after the result is
//   registered; a new word is taken while the last result waits.
// Reset empties the set (count zero); the entry memory itself is not cleared.
`timescale 1ns / 1ps

module sorted_set_table_unit #(
    parameter int CAPACITY    = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  sst_pkg::t_mode                   i_mode,
    input  logic [sst_pkg::IN_VALUE_W-1:0]   i_value,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output sst_pkg::t_status                 o_status,
    output logic                             o_found,
    output logic [sst_pkg::POS_W-1:0]        o_position,
    output logic [sst_pkg::CNT_W-1:0]        o_element_count
);
    import sst_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    sst_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_mode      (i_mode),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready)
    );

    sst_dpath #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_mode          (i_mode),
        .i_value         (i_value),
        .o_stat          (stat),
        .o_status        (o_status),
        .o_found         (o_found),
        .o_position      (o_position),
        .o_element_count (o_element_count)
    );

endmodule

/* src/sst_dpath.sv */
// Datapath of the sorted set table: entry memory, scan and shift pointers, result registers.
`timescale 1ns / 1ps

module sst_dpath #(
    parameter int CAPACITY    = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  sst_pkg::t_cmd                    i_cmd,
    input  sst_pkg::t_mode                   i_mode,
    input  logic [sst_pkg::IN_VALUE_W-1:0]   i_value,
    output sst_pkg::t_stat                   o_stat,
    output sst_pkg::t_status                 o_status,
    output logic                             o_found,
    output logic [sst_pkg::POS_W-1:0]        o_position,
    output logic [sst_pkg::CNT_W-1:0]        o_element_count
);
    import sst_pkg::*;

    // Stored values never exceed the input field width
    localparam int SW = (VALUE_WIDTH < IN_VALUE_W) ? VALUE_WIDTH : IN_VALUE_W;
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    // Entry memory
    logic [SW-1:0] mem [CAPACITY];
    logic [SW-1:0] r_rdata;

    logic          rd_en;
    logic [CW-1:0] rd_idx;
    logic          wr_en;
    logic [CW-1:0] wr_idx;
    logic [SW-1:0] wr_data;

    // Request and pointer state
    t_mode         r_mode;
    logic [SW-1:0] r_v;
    logic [CW-1:0] r_idx,    n_idx;
    logic          r_vld,    n_vld;
    logic [CW-1:0] r_pos,    n_pos;
    logic [CW-1:0] r_count,  n_count;
    t_status       r_status, n_status;
    logic          r_found,  n_found;

    // Result word
    t_status             r_o_status;
    logic                r_o_found;
    logic [POS_W-1:0]    r_o_pos;
    logic [CNT_W-1:0]    r_o_cnt;

    logic          hit_eq;
    logic          hit_gt;
    logic          at_end;
    logic          scan_done;
    logic          full;
    logic          up_done;
    logic          down_done;
    logic [CW:0]   idx_p1;
    logic [CW:0]   idx_p2;
    logic [CW-1:0] idx_m1;

    // Scan compare on the word read last cycle
    assign hit_eq    = r_vld && (r_rdata == r_v);
    assign hit_gt    = r_vld && (r_rdata > r_v);
    assign at_end    = (r_idx == r_count);
    assign scan_done = hit_eq || hit_gt || at_end;
    assign full      = (r_count == CW'(CAPACITY));
    assign idx_p1    = (CW + 1)'(r_idx) + (CW + 1)'(1);
    assign idx_p2    = (CW + 1)'(r_idx) + (CW + 1)'(2);
    assign idx_m1    = r_idx - CW'(1);
    assign up_done   = (r_idx == r_pos);
    assign down_done = (idx_p1 >= (CW + 1)'(r_count));

    assign o_stat.scan_done  = scan_done;
    assign o_stat.found      = hit_eq;
    assign o_stat.full       = full;
    assign o_stat.shift_done = (r_mode == MODE_INSERT) ? up_done : down_done;
    assign o_stat.mode       = r_mode;

    // Next-state and memory access decode
    always_comb begin
        n_idx    = r_idx;
        n_vld    = r_vld;
        n_pos    = r_pos;
        n_count  = r_count;
        n_status = r_status;
        n_found  = r_found;
        rd_en    = 1'b0;
        rd_idx   = r_idx;
        wr_en    = 1'b0;
        wr_idx   = r_idx;
        wr_data  = r_rdata;
        unique case (i_cmd)
            CMD_LOAD: begin
                n_idx    = '0;
                n_vld    = 1'b0;
                n_pos    = '0;
                n_status = STAT_OK;
                n_found  = 1'b0;
                if (i_mode == MODE_CLEAR) begin
                    n_count = '0;
                end
            end
            CMD_SCAN: begin
                if (scan_done) begin
                    n_vld   = 1'b0;
                    n_found = hit_eq;
                    n_pos   = (hit_eq || hit_gt) ? idx_m1 : r_idx;
                    if (hit_eq) begin
                        n_status = (r_mode == MODE_INSERT) ? STAT_MISS : STAT_OK;
                    end else if (r_mode == MODE_INSERT) begin
                        n_status = full ? STAT_FULL : STAT_OK;
                    end else begin
                        n_status = STAT_MISS;
                    end
                    // Insert shifts down from the top, erase up from the hit
                    n_idx = (r_mode == MODE_ERASE) ? idx_m1 : r_count;
                end else begin
                    rd_en  = 1'b1;
                    rd_idx = r_idx;
                    n_idx  = r_idx + CW'(1);
                    n_vld  = 1'b1;
                end
            end
            CMD_UP: begin
                if (up_done) begin
                    wr_en   = 1'b1;
                    wr_idx  = r_pos;
                    wr_data = r_v;
                    n_count = r_count + CW'(1);
                end else if (!r_vld) begin
                    rd_en  = 1'b1;
                    rd_idx = idx_m1;
                    n_vld  = 1'b1;
                end else begin
                    wr_en  = 1'b1;
                    wr_idx = r_idx;
                    n_idx  = idx_m1;
                    if (idx_m1 > r_pos) begin
                        rd_en  = 1'b1;
                        rd_idx = r_idx - CW'(2);
                        n_vld  = 1'b1;
                    end else begin
                        n_vld = 1'b0;
                    end
                end
            end
            CMD_DOWN: begin
                if (down_done) begin
                    n_count = r_count - CW'(1);
                end else if (!r_vld) begin
                    rd_en  = 1'b1;
                    rd_idx = idx_p1[CW-1:0];
                    n_vld  = 1'b1;
                end else begin
                    wr_en  = 1'b1;
                    wr_idx = r_idx;
                    n_idx  = idx_p1[CW-1:0];
                    if (idx_p2 < (CW + 1)'(r_count)) begin
                        rd_en  = 1'b1;
                        rd_idx = idx_p2[CW-1:0];
                        n_vld  = 1'b1;
                    end else begin
                        n_vld = 1'b0;
                    end
                end
            end
            CMD_NONE, CMD_OUT: begin
            end
            default: begin
            end
        endcase
    end

    // Memory ports
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_idx[AW-1:0]] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= mem[rd_idx[AW-1:0]];
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_vld   <= 1'b0;
        end else begin
            r_count <= n_count;
            r_vld   <= n_vld;
        end
    end

    // Pointers and pending result
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_pos    <= n_pos;
        r_status <= n_status;
        r_found  <= n_found;
        if (i_cmd == CMD_LOAD) begin
            r_mode <= i_mode;
            r_v    <= SW'(i_value);
        end
    end

    // Output word register
    always_ff @(posedge i_clk) begin
        if (i_cmd == CMD_OUT) begin
            r_o_status <= r_status;
            r_o_found  <= r_found;
            r_o_pos    <= ((r_status == STAT_OK) || r_found) ? POS_W'(r_pos) : '0;
            r_o_cnt    <= CNT_W'(r_count);
        end
    end

    assign o_status        = r_o_status;
    assign o_found         = r_o_found;
    assign o_position      = r_o_pos;
    assign o_element_count = r_o_cnt;

endmodule

/* src/sst_ctrl.sv */
// Controller state machine of the sorted set table.
`timescale 1ns / 1ps

module sst_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  sst_pkg::t_mode  i_mode,
    input  sst_pkg::t_stat  i_stat,
    output sst_pkg::t_cmd   o_cmd,
    output logic            o_out_valid,
    input  logic            i_out_ready
);
    import sst_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_UP   = 3'd2;
    localparam logic [2:0] S_DOWN = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    t_cmd       cmd;

    // Sequencing
    always_comb begin
        n_state = r_state;
        cmd     = CMD_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd     = CMD_LOAD;
                    n_state = (i_mode == MODE_CLEAR) ? S_FIN : S_SCAN;
                end
            end
            S_SCAN: begin
                cmd = CMD_SCAN;
                if (i_stat.scan_done) begin
                    priority if ((i_stat.mode == MODE_INSERT) && !i_stat.found
                                 && !i_stat.full) begin
                        n_state = S_UP;
                    end else if ((i_stat.mode == MODE_ERASE) && i_stat.found) begin
                        n_state = S_DOWN;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_UP: begin
                cmd = CMD_UP;
                if (i_stat.shift_done) begin
                    n_state = S_FIN;
                end
            end
            S_DOWN: begin
                cmd = CMD_DOWN;
                if (i_stat.shift_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // Hand over once the output register is free
                if (!r_out_valid || i_out_ready) begin
                    cmd     = CMD_OUT;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output word valid
    always_comb begin
        n_out_valid = r_out_valid;
        if (cmd == CMD_OUT) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cmd       = cmd;
    assign o_out_valid = r_out_valid;

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for the sorted set table unit.
`timescale 1ns / 1ps

module tb_top;
    import sst_pkg::*;

    localparam int SET_CAP      = 16;
    localparam int VAL_W        = 32;
    localparam int RANDOM_ITEMS = 1500;
    localparam int QUIET_ITEMS  = 300;     // tail of the random part with no idling
    localparam int DRAIN_CYCLES = 64;      // beyond the worst insert/erase latency
    localparam int DRAIN_LIMIT  = 20000;

    // One result word as the block reports it
    typedef struct packed {
        t_status            status;
        logic               found;
        logic [POS_W-1:0]   position;
        logic [CNT_W-1:0]   count;
    } t_set_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_ready;
    t_mode                  i_mode;
    logic [IN_VALUE_W-1:0]  i_value;
    logic                   o_out_valid;
    logic                   i_out_ready;
    t_status                o_status;
    logic                   o_found;
    logic [POS_W-1:0]       o_position;
    logic [CNT_W-1:0]       o_element_count;

    // Shadow of the set contents, kept sorted
    logic [VAL_W-1:0]       shadow_vals [SET_CAP];
    int                     shadow_len = 0;

    t_set_result            result_queue [$];
    int                     fail_count   = 0;
    int                     result_index = 0;
    bit                     quiet_tail   = 1'b0;

    sorted_set_table_unit #(
        .CAPACITY    (SET_CAP),
        .VALUE_WIDTH (VAL_W)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_mode          (i_mode),
        .i_value         (i_value),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_found         (o_found),
        .o_position      (o_position),
        .o_element_count (o_element_count)
    );

    always #5 i_clk = ~i_clk;

    // Apply one request to the shadow set and return the result it should give
    function automatic t_set_result set_apply(input t_mode mode, input logic [VAL_W-1:0] v);
        t_set_result r;
        int          hit;
        int          slot;
        r   = '{status: STAT_OK, found: 1'b0, position: '0, count: '0};
        hit = -1;
        for (int i = 0; i < shadow_len; i++) begin
            if (hit < 0 && shadow_vals[i] == v) hit = i;
        end
        case (mode)
            MODE_INSERT: begin
                if (hit >= 0) begin
                    r.status   = STAT_MISS;
                    r.found    = 1'b1;
                    r.position = POS_W'(hit);
                end else if (shadow_len >= SET_CAP) begin
                    r.status = STAT_FULL;
                end else begin
                    slot = 0;
                    while (slot < shadow_len && shadow_vals[slot] <= v) slot++;
                    for (int i = shadow_len; i > slot; i--) shadow_vals[i] = shadow_vals[i-1];
                    shadow_vals[slot] = v;
                    shadow_len++;
                    r.position = POS_W'(slot);
                end
            end
            MODE_FIND: begin
                if (hit >= 0) begin
                    r.found    = 1'b1;
                    r.position = POS_W'(hit);
                end else begin
                    r.status = STAT_MISS;
                end
            end
            MODE_ERASE: begin
                if (hit >= 0) begin
                    r.found    = 1'b1;
                    r.position = POS_W'(hit);
                    for (int i = hit; i + 1 < shadow_len; i++) shadow_vals[i] = shadow_vals[i+1];
                    shadow_len--;
                end else begin
                    r.status = STAT_MISS;
                end
            end
            default: shadow_len = 0;
        endcase
        r.count = CNT_W'(shadow_len);
        return r;
    endfunction

    task automatic report_failure(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        fail_count++;
    endtask

    // Send one request word; may idle first. Returns in the step of acceptance,
    // with valid left high so back-to-back words need no second assignment.
    task automatic send_word(input t_mode mode, input logic [VAL_W-1:0] v);
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode     <= mode;
        i_value    <= v;
        do @(posedge i_clk); while (!o_in_ready);
        result_queue.push_back(set_apply(mode, v));
    endtask

    // Random value: often a stored value or one above it, so hits are common
    function automatic logic [VAL_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35 && shadow_len > 0) return shadow_vals[$urandom_range(0, shadow_len - 1)];
        if (r < 45 && shadow_len > 0) return shadow_vals[$urandom_range(0, shadow_len - 1)] + 1;
        if (r < 70) return VAL_W'($urandom_range(0, 31));
        if (r < 80) begin
            case ($urandom_range(0, 3))
                0:       return '0;
                1:       return '1;
                2:       return 32'h8000_0000;
                default: return 32'h7FFF_FFFF;
            endcase
        end
        return $urandom();
    endfunction

    // Growing phases favour insert so the table often fills; shrinking ones favour erase
    function automatic t_mode pick_mode(input bit growing);
        int r;
        r = $urandom_range(0, 99);
        if (r == 0) return MODE_CLEAR;
        if (growing) return (r < 60) ? MODE_INSERT : (r < 80) ? MODE_FIND : MODE_ERASE;
        return (r < 25) ? MODE_INSERT : (r < 45) ? MODE_FIND : MODE_ERASE;
    endfunction

    task automatic test_empty_table();
        send_word(MODE_FIND,  32'h0000_0000);
        send_word(MODE_ERASE, 32'hFFFF_FFFF);
    endtask

    // Front, back and middle inserts, extremes included, up to capacity
    task automatic test_fill_to_capacity();
        logic [VAL_W-1:0] fill_vals [SET_CAP];
        fill_vals = '{32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                      32'h0000_0001, 32'hFFFF_FFFE, 32'h0000_0005, 32'h0000_0003,
                      32'h0000_03E8, 32'h0000_03E7, 32'hAAAA_AAAA, 32'h5555_5555,
                      32'h0000_FFFF, 32'hFFFF_0000, 32'h1234_5678, 32'h0F0F_0F0F};
        foreach (fill_vals[i]) send_word(MODE_INSERT, fill_vals[i]);
    endtask

    // New value refused when full; a duplicate still reports its position
    task automatic test_full_table();
        send_word(MODE_INSERT, 32'h4242_4242);
        send_word(MODE_INSERT, 32'h0000_0000);
    endtask

    task automatic test_find_and_erase();
        send_word(MODE_FIND,  32'hFFFF_FFFF);
        send_word(MODE_FIND,  32'h0000_0002);
        send_word(MODE_ERASE, 32'h0000_0000);
        send_word(MODE_ERASE, 32'hFFFF_FFFF);
        send_word(MODE_ERASE, 32'h0000_0002);
        send_word(MODE_CLEAR, 32'h1234_5678);
    endtask

    task automatic test_random_mix();
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            quiet_tail = (i >= RANDOM_ITEMS - QUIET_ITEMS);
            send_word(pick_mode(((i / 100) % 2) == 0), pick_value());
        end
    endtask

    // Result side: random stall bursts, none in the quiet tail
    initial begin
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!quiet_tail && $urandom_range(0, 7) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
        end
    end

    // Compare each accepted result word with the oldest prediction
    always @(posedge i_clk) begin
        t_set_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (result_queue.size() == 0) begin
                report_failure($sformatf("result word %0d with nothing pending", result_index));
            end else begin
                want = result_queue.pop_front();
                if (o_status !== want.status)
                    report_failure($sformatf("word %0d status %0d, want %0d",
                                             result_index, o_status, want.status));
                if (o_found !== want.found)
                    report_failure($sformatf("word %0d found %0b, want %0b",
                                             result_index, o_found, want.found));
                if (o_position !== want.position)
                    report_failure($sformatf("word %0d position %0d, want %0d",
                                             result_index, o_position, want.position));
                if (o_element_count !== want.count)
                    report_failure($sformatf("word %0d count %0d, want %0d",
                                             result_index, o_element_count, want.count));
            end
            result_index++;
        end
    end

    // Main sequence
    initial begin
        int guard;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_mode     <= MODE_INSERT;
        i_value    <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n    <= 1'b1;

        test_empty_table();
        test_fill_to_capacity();
        test_full_table();
        test_find_and_erase();
        test_random_mix();
        i_in_valid <= 1'b0;

        // Drain outstanding results
        guard = 0;
        while (result_queue.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        if (result_queue.size() != 0)
            report_failure($sformatf("%0d results never arrived", result_queue.size()));
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
